### hdl/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and codes for the sorted priority list: commands, status
// codes, cell match modes, cell actions and the controller states.
// ----------------------------------------------------------------------------
package spl_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND      = 3'd0,
        CMD_PREPEND     = 3'd1,
        CMD_SORT_INSERT = 3'd2,
        CMD_REMOVE_HEAD = 3'd3,
        CMD_READ_INDEX  = 3'd4,
        CMD_REMOVE_INDEX = 3'd5,
        CMD_REMOVE_ITEM = 3'd6,
        CMD_CLEAR       = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADIDX   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // which cells are candidates for the operation point
    typedef enum logic [2:0] {
        MODE_ALL,
        MODE_FREE,
        MODE_SORT,
        MODE_POS,
        MODE_ITEM
    } t_mode;

    // what the cells do with their contents this cycle
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_REMOVE
    } t_act;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_mode              mode;
        logic [DATA_W-1:0]  item;
        logic [DATA_W-1:0]  key;
        logic [POS_W-1:0]   pos;
    } t_bcast;

endpackage

### hdl/spl_cmd_if.sv
// ----------------------------------------------------------------------------
// spl_cmd_if
// Command channel of the sorted priority list: valid, ready and payload.
// ----------------------------------------------------------------------------
interface spl_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [spl_pkg::CMD_W-1:0]    cmd;
    logic [spl_pkg::DATA_W-1:0]   item_handle;
    logic signed [spl_pkg::DATA_W-1:0] sort_key;
    logic [spl_pkg::POS_W-1:0]    position;

    modport source (output valid, cmd, item_handle, sort_key, position, input ready);
    modport sink   (input valid, cmd, item_handle, sort_key, position, output ready);
endinterface

### hdl/spl_res_if.sv
// ----------------------------------------------------------------------------
// spl_res_if
// Result channel of the sorted priority list: valid, ready and payload.
// ----------------------------------------------------------------------------
interface spl_res_if;
    logic                         valid;
    logic                         ready;
    logic [spl_pkg::STATUS_W-1:0] status;
    logic [spl_pkg::DATA_W-1:0]   out_item;
    logic signed [spl_pkg::DATA_W-1:0] out_key;
    logic [spl_pkg::COUNT_W-1:0]  entry_count;
    logic                         is_empty;

    modport source (output valid, status, out_item, out_key, entry_count, is_empty,
                    input ready);
    modport sink   (input valid, status, out_item, out_key, entry_count, is_empty,
                    output ready);
endinterface

### hdl/sorted_priority_list.sv
// ----------------------------------------------------------------------------
// sorted_priority_list
// Bounded ordered list of (item handle, key) entries held in a chain of
// cells, with append, prepend, stable sorted insert, indexed read, removal and clear commands.
// ----------------------------------------------------------------------------
// Usage
//   i_cmd carries one command per transfer; o_res returns exactly one result
//   per command, in order, with status, the removed or read entry, the entry
//   count after the command and an empty flag.
//   A command is registered on acceptance; in the execute state every cell
//   compares against it and shifts with its neighbors in one step, and the
//   result is loaded into the output register. No new command is accepted
//   until the controller has gone back from execute to idle.
//   The seen flag ripples through all CAPACITY cells in the execute cycle.
//   Reset empties the list; slot contents are not cleared and need no sweep.
//   When the receiver stalls, the result waits in the output register; the
//   next command is still accepted and executes as soon as that register
//   frees up, so no result is lost or overwritten.
// ----------------------------------------------------------------------------
module sorted_priority_list #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spl_cmd_if.sink    i_cmd,
    spl_res_if.source  o_res
);
    import spl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [DATA_W-1:0]   r_item;
    logic [DATA_W-1:0]   r_key;
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_count, n_count;

    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [DATA_W-1:0]   r_out_item, n_out_item;
    logic [DATA_W-1:0]   r_out_key, n_out_key;
    logic [CNT_W-1:0]    r_out_count;

    t_bcast              w_bcast;
    t_act                w_act;
    logic                w_commit;
    logic [CAPACITY:0]   w_seen;
    logic [CAPACITY-1:0] w_hit;
    logic [DATA_W-1:0]   w_cell_item [CAPACITY];
    logic [DATA_W-1:0]   w_cell_key  [CAPACITY];
    logic [DATA_W-1:0]   w_sel_item;
    logic [DATA_W-1:0]   w_sel_key;
    logic                w_full;
    logic                w_empty;
    logic                w_badidx;
    logic                w_found;
    logic [31:0]         w_count_ext;

    // broadcast from the registered command
    always_comb begin
        w_bcast.item = r_item;
        w_bcast.pos  = r_pos;
        w_bcast.key  = (r_cmd == CMD_SORT_INSERT) ? r_key : '0;
        case (r_cmd)
            CMD_APPEND:       w_bcast.mode = MODE_FREE;
            CMD_SORT_INSERT:  w_bcast.mode = MODE_SORT;
            CMD_READ_INDEX,
            CMD_REMOVE_INDEX: w_bcast.mode = MODE_POS;
            CMD_REMOVE_ITEM:  w_bcast.mode = MODE_ITEM;
            default:          w_bcast.mode = MODE_ALL;
        endcase
    end

    // chain of cells
    assign w_seen[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_l_item, w_l_key, w_r_item, w_r_key;
        if (g == 0) begin : g_first
            assign w_l_item = w_bcast.item;
            assign w_l_key  = w_bcast.key;
        end else begin : g_mid
            assign w_l_item = w_cell_item[g-1];
            assign w_l_key  = w_cell_key[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_r_item = w_cell_item[g];
            assign w_r_key  = w_cell_key[g];
        end else begin : g_inner
            assign w_r_item = w_cell_item[g+1];
            assign w_r_key  = w_cell_key[g+1];
        end
        spl_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_bcast      (w_bcast),
            .i_act        (w_act),
            .i_count      (r_count),
            .i_seen       (w_seen[g]),
            .o_seen       (w_seen[g+1]),
            .o_hit        (w_hit[g]),
            .i_left_item  (w_l_item),
            .i_left_key   (w_l_key),
            .i_right_item (w_r_item),
            .i_right_key  (w_r_key),
            .o_item       (w_cell_item[g]),
            .o_key        (w_cell_key[g])
        );
    end

    // pick the hit entry
    always_comb begin
        w_sel_item = '0;
        w_sel_key  = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_sel_item = w_sel_item | (w_hit[k] ? w_cell_item[k] : '0);
            w_sel_key  = w_sel_key  | (w_hit[k] ? w_cell_key[k]  : '0);
        end
    end

    assign w_full   = r_count >= CNT_W'(CAPACITY);
    assign w_empty  = r_count == '0;
    assign w_badidx = (r_pos == '0) || (32'(r_pos) > 32'(r_count));
    assign w_found  = w_seen[CAPACITY];
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || o_res.ready);

    // command decode: status, action, result and new count
    always_comb begin
        n_status   = ST_OK;
        w_act      = ACT_NONE;
        n_out_item = '0;
        n_out_key  = '0;
        n_count    = r_count;
        case (r_cmd)
            CMD_APPEND, CMD_PREPEND, CMD_SORT_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_act   = ACT_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REMOVE_HEAD: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_act      = ACT_REMOVE;
                    n_out_item = w_sel_item;
                    n_out_key  = w_sel_key;
                    n_count    = r_count - 1'b1;
                end
            end
            CMD_READ_INDEX, CMD_REMOVE_INDEX: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (w_badidx) begin
                    n_status = ST_BADIDX;
                end else begin
                    n_out_item = w_sel_item;
                    n_out_key  = w_sel_key;
                    if (r_cmd == CMD_REMOVE_INDEX) begin
                        w_act   = ACT_REMOVE;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_REMOVE_ITEM: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    w_act      = ACT_REMOVE;
                    n_out_item = w_sel_item;
                    n_out_key  = w_sel_key;
                    n_count    = r_count - 1'b1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
        // cells change only when the result is committed
        if (!w_commit) begin
            w_act = ACT_NONE;
        end
    end

    // controller next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_cmd.valid) n_state = S_EXEC;
            S_EXEC:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command and result payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd  <= t_cmd'(i_cmd.cmd);
            r_item <= i_cmd.item_handle;
            r_key  <= i_cmd.sort_key;
            r_pos  <= i_cmd.position;
        end
        if (w_commit) begin
            r_status    <= n_status;
            r_out_item  <= n_out_item;
            r_out_key   <= n_out_key;
            r_out_count <= n_count;
        end
    end

    assign w_count_ext = 32'(r_out_count);

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.out_item    = r_out_item;
    assign o_res.out_key     = r_out_key;
    assign o_res.entry_count = w_count_ext[COUNT_W-1:0];
    assign o_res.is_empty    = (r_out_count == '0);

endmodule

### hdl/spl_cell.sv
// ----------------------------------------------------------------------------
// spl_cell
// One slot of the list. Decides locally whether it is a candidate for the
// operation point, passes a seen flag to its right neighbor and holds,
// loads the new entry, or shifts from its left or right neighbor.
// ----------------------------------------------------------------------------
module spl_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                        i_clk,
    input  spl_pkg::t_bcast             i_bcast,
    input  spl_pkg::t_act               i_act,
    input  logic [CNT_W-1:0]            i_count,
    input  logic                        i_seen,
    output logic                        o_seen,
    output logic                        o_hit,
    input  logic [spl_pkg::DATA_W-1:0]  i_left_item,
    input  logic [spl_pkg::DATA_W-1:0]  i_left_key,
    input  logic [spl_pkg::DATA_W-1:0]  i_right_item,
    input  logic [spl_pkg::DATA_W-1:0]  i_right_key,
    output logic [spl_pkg::DATA_W-1:0]  o_item,
    output logic [spl_pkg::DATA_W-1:0]  o_key
);
    import spl_pkg::*;

    logic [DATA_W-1:0] r_item, n_item;
    logic [DATA_W-1:0] r_key,  n_key;
    logic              w_valid;
    logic              w_lt;
    logic              w_cand;

    // slot holds an entry when it lies below the count
    assign w_valid = i_count > CNT_W'(IDX);
    assign w_lt    = $signed(i_bcast.key) < $signed(r_key);

    // local candidate test
    always_comb begin
        case (i_bcast.mode)
            MODE_ALL:  w_cand = 1'b1;
            MODE_FREE: w_cand = !w_valid;
            MODE_SORT: w_cand = !w_valid || w_lt;
            MODE_POS:  w_cand = w_valid && (32'(i_bcast.pos) == 32'(IDX + 1));
            MODE_ITEM: w_cand = w_valid && (i_bcast.item == r_item);
            default:   w_cand = 1'b0;
        endcase
    end

    // first candidate along the chain is the hit
    assign o_hit  = w_cand && !i_seen;
    assign o_seen = i_seen || w_cand;

    // shift, load or hold
    always_comb begin
        n_item = r_item;
        n_key  = r_key;
        case (i_act)
            ACT_INSERT: begin
                if (i_seen) begin
                    n_item = i_left_item;
                    n_key  = i_left_key;
                end else if (w_cand) begin
                    n_item = i_bcast.item;
                    n_key  = i_bcast.key;
                end
            end
            ACT_REMOVE: begin
                if (o_seen) begin
                    n_item = i_right_item;
                    n_key  = i_right_key;
                end
            end
            default: begin
                n_item = r_item;
                n_key  = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_key  <= n_key;
    end

    assign o_item = r_item;
    assign o_key  = r_key;

endmodule
